/* hdl/ipcs_pkg.sv */
// constants and helper functions for the internet checksum engine
package ipcs_pkg;

   localparam int WORD_W = 16;
   localparam int CNT_W  = 15;
   localparam int ASUM_W = 19;
   localparam int TREE_W = 19;

   localparam logic MODE_IP  = 1'b0;
   localparam logic MODE_TCP = 1'b1;

   localparam logic [CNT_W-1:0]  IP_CKSUM_POS  = 15'd5;
   localparam logic [CNT_W-1:0]  TCP_CKSUM_POS = 15'd8;
   localparam logic [WORD_W-1:0] PROTO_TCP     = 16'h0006;
   localparam logic [WORD_W-1:0] HIGH_BYTE     = 16'hFF00;

   typedef logic [WORD_W-1:0] word_type;

   // end-around carry fold of a wide sum down to 16 bits
   function automatic word_type fold_sum(input logic [TREE_W-1:0] s);
      logic [WORD_W:0] f1;
      logic [WORD_W:0] f2;
      f1 = {1'b0, s[WORD_W-1:0]} + {{(WORD_W+1-(TREE_W-WORD_W)){1'b0}}, s[TREE_W-1:WORD_W]};
      f2 = {1'b0, f1[WORD_W-1:0]} + {{WORD_W{1'b0}}, f1[WORD_W]};
      return f2[WORD_W-1:0];
   endfunction

endpackage

/* hdl/ip_tcp_checksum_engine.sv */
// internet checksum engine: streamed 16-bit words, ip header or tcp segment with pseudo-header
//
//  channel  direction  ports
//  req      in         req_valid/req_ready, mode, start_req, data_word, addresses, lengths
//  rsp      out        rsp_valid/rsp_ready, checksum, unit_mode
//
// one word per cycle sustained unless the result stalls; words pass the input register first.
// the input register pre-adds the pseudo-header address halves and the protocol number,
// stage two adds these, the length and the first word: one 19-bit add, double end-around fold.
// reset is synchronous; it drops any unit in progress and empties both registers.
// a stalled result holds the word stage; words keep flowing while the result register is free
// or being drained in the same cycle.
module ip_tcp_checksum_engine
   import ipcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic        req_start_req,
   input  logic [15:0] req_data_word,
   input  logic [31:0] req_source_address,
   input  logic [31:0] req_dest_address,
   input  logic [15:0] req_total_length,
   input  logic [3:0]  req_header_words,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_checksum,
   output logic        rsp_unit_mode
);

   // input stage
   logic              in_valid_ff, in_valid_in;
   logic              in_mode_ff;
   logic              in_start_ff;
   word_type          in_word_ff;
   word_type          in_bytes_ff, in_bytes_in;
   logic [ASUM_W-1:0] in_asum_ff, in_asum_in;

   // unit state
   word_type          running_sum_ff, running_sum_in;
   logic [CNT_W-1:0]  words_left_ff, words_left_in;
   logic [CNT_W-1:0]  word_position_ff, word_position_in;
   logic              odd_tail_ff, odd_tail_in;
   logic              busy_ff, busy_in;
   logic              held_mode_ff, held_mode_in;

   // result register
   logic              out_valid_ff, out_valid_in;
   word_type          out_sum_ff, out_sum_in;
   logic              out_mode_ff, out_mode_in;

   logic              proceed;
   logic              fire;
   logic              emit;
   word_type          header_bytes;
   word_type          wordm;
   logic [CNT_W-1:0]  start_wl;
   logic              start_ot;
   logic [TREE_W-1:0] tree;
   logic [WORD_W:0]   step_sum;
   logic [CNT_W-1:0]  cks_pos;

   assign proceed   = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && proceed;
   assign req_ready = !in_valid_ff || proceed;

   assign rsp_valid     = out_valid_ff;
   assign rsp_checksum  = out_sum_ff;
   assign rsp_unit_mode = out_mode_ff;

   // pre-add of the pseudo-header ahead of the input register
   assign header_bytes = {10'd0, req_header_words, 2'b00};
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      in_bytes_in = (req_mode == MODE_TCP) ? (req_total_length - header_bytes) : header_bytes;
      in_asum_in  = {3'b000, req_source_address[31:16]} + {3'b000, req_source_address[15:0]}
                  + {3'b000, req_dest_address[31:16]} + {3'b000, req_dest_address[15:0]}
                  + {3'b000, PROTO_TCP};
   end

   assign start_wl = in_bytes_ff[WORD_W-1:1];
   assign start_ot = in_bytes_ff[0];
   assign cks_pos  = (held_mode_ff == MODE_TCP) ? TCP_CKSUM_POS : IP_CKSUM_POS;

   always_comb begin
      running_sum_in   = running_sum_ff;
      words_left_in    = words_left_ff;
      word_position_in = word_position_ff;
      odd_tail_in      = odd_tail_ff;
      busy_in          = busy_ff;
      held_mode_in     = held_mode_ff;
      emit             = 1'b0;
      wordm            = in_word_ff;
      tree             = '0;
      step_sum         = '0;

      if (fire && in_start_ff) begin
         held_mode_in     = in_mode_ff;
         word_position_in = 15'd1;
         // position zero is never the checksum slot; only the odd-byte mask applies
         if (start_wl == '0) begin
            wordm = in_word_ff & HIGH_BYTE;
         end
         if (start_wl == '0 && !start_ot) begin
            wordm = '0;
         end
         if (in_mode_ff == MODE_TCP) begin
            tree = in_asum_ff + {3'b000, in_bytes_ff} + {3'b000, wordm};
         end else begin
            tree = {3'b000, wordm};
         end
         running_sum_in = fold_sum(tree);
         if (start_wl == '0 && !start_ot) begin
            emit             = 1'b1;
            busy_in          = 1'b0;
            words_left_in    = '0;
            odd_tail_in      = 1'b0;
            word_position_in = '0;
         end else begin
            if (start_wl != '0) begin
               words_left_in = start_wl - 15'd1;
               odd_tail_in   = start_ot;
            end else begin
               words_left_in = '0;
               odd_tail_in   = 1'b0;
            end
            emit    = (words_left_in == '0) && !odd_tail_in;
            busy_in = !emit;
         end
      end else if (fire && busy_ff) begin
         if (word_position_ff == cks_pos) begin
            wordm = '0;
         end
         if (words_left_ff == '0) begin
            wordm = wordm & HIGH_BYTE;
         end
         step_sum       = {1'b0, running_sum_ff} + {1'b0, wordm};
         running_sum_in = step_sum[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, step_sum[WORD_W]};
         if (words_left_ff != '0) begin
            words_left_in = words_left_ff - 15'd1;
         end else begin
            odd_tail_in = 1'b0;
         end
         word_position_in = word_position_ff + 15'd1;
         emit    = (words_left_in == '0) && !odd_tail_in;
         busy_in = !emit;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_sum_in   = out_sum_ff;
      out_mode_in  = out_mode_ff;
      if (fire && emit) begin
         out_valid_in = 1'b1;
         out_sum_in   = ~running_sum_in;
         out_mode_in  = held_mode_in;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         running_sum_ff   <= '0;
         words_left_ff    <= '0;
         word_position_ff <= '0;
         odd_tail_ff      <= 1'b0;
         busy_ff          <= 1'b0;
         held_mode_ff     <= 1'b0;
      end else begin
         in_valid_ff      <= in_valid_in;
         out_valid_ff     <= out_valid_in;
         running_sum_ff   <= running_sum_in;
         words_left_ff    <= words_left_in;
         word_position_ff <= word_position_in;
         odd_tail_ff      <= odd_tail_in;
         busy_ff          <= busy_in;
         held_mode_ff     <= held_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_mode_ff  <= req_mode;
         in_start_ff <= req_start_req;
         in_word_ff  <= req_data_word;
         in_bytes_ff <= in_bytes_in;
         in_asum_ff  <= in_asum_in;
      end
      out_sum_ff  <= out_sum_in;
      out_mode_ff <= out_mode_in;
   end

endmodule
